>>> rtl/cvsr_pkg.sv
// ----------------------------------------------------------------------------
// Cartesian vector shift ranks: shared package
// Field widths, register indexes and the configuration bundle used by
// every module of the neighbor rank pipeline.
// ----------------------------------------------------------------------------
package cvsr_pkg;

	// Fixed field widths.
	localparam int SIZE_BITS  = 8;
	localparam int RANK_BITS  = 32;
	localparam int NDIM_BITS  = 3;
	localparam int PMASK_BITS = 4;
	localparam int CFG_BITS   = 32;
	localparam int FIELD_DIMS = 4;

	// Remainder bits resolved per modulo pipeline stage.
	localparam int STEP_BITS = 8;

	// Result directions.
	localparam int NUM_DIRS = 2;
	localparam int DIR_DEST = 0;
	localparam int DIR_SRC  = 1;

	// Configuration register indexes.
	typedef enum logic [NDIM_BITS-1:0] {
		CFG_NUM_DIMS      = 3'd0,
		CFG_SIZE_0        = 3'd1,
		CFG_SIZE_1        = 3'd2,
		CFG_SIZE_2        = 3'd3,
		CFG_SIZE_3        = 3'd4,
		CFG_PERIODIC_MASK = 3'd5,
		CFG_OWN_COORDS    = 3'd6
	} cfg_idx_t;

	// Effective configuration: sizes and dimension count already clamped.
	typedef struct packed {
		logic [NDIM_BITS-1:0]                  num_dims;
		logic [FIELD_DIMS-1:0][SIZE_BITS-1:0]  size;
		logic [PMASK_BITS-1:0]                 periodic;
		logic [CFG_BITS-1:0]                   own_coords;
	} cfg_t;

endpackage

>>> rtl/cvsr_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the grid description. Sizes of zero are stored as one and the
// dimension count is clamped to 1..MAX_DIMS when written.
// ----------------------------------------------------------------------------
module cvsr_cfg #(
	parameter int MAX_DIMS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [cvsr_pkg::NDIM_BITS-1:0]    index,
	input  logic [cvsr_pkg::CFG_BITS-1:0]     wdata,
	output cvsr_pkg::cfg_t                    cfg
);

	cvsr_pkg::cfg_t                   cfg_q;
	logic [cvsr_pkg::NDIM_BITS-1:0]   nd_wr;
	logic [cvsr_pkg::SIZE_BITS-1:0]   size_wr;

	// Clamp the written values to their effective range.
	always_comb begin
		nd_wr = wdata[cvsr_pkg::NDIM_BITS-1:0];
		if (nd_wr == '0) begin
			nd_wr = cvsr_pkg::NDIM_BITS'(1);
		end else if (nd_wr > cvsr_pkg::NDIM_BITS'(MAX_DIMS)) begin
			nd_wr = cvsr_pkg::NDIM_BITS'(MAX_DIMS);
		end
		size_wr = wdata[cvsr_pkg::SIZE_BITS-1:0];
		if (size_wr == '0) begin
			size_wr = cvsr_pkg::SIZE_BITS'(1);
		end
	end

	// Register file write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_dims   <= cvsr_pkg::NDIM_BITS'(1);
			cfg_q.size       <= {cvsr_pkg::FIELD_DIMS{cvsr_pkg::SIZE_BITS'(1)}};
			cfg_q.periodic   <= '0;
			cfg_q.own_coords <= '0;
		end else if (we) begin
			case (cvsr_pkg::cfg_idx_t'(index))
				cvsr_pkg::CFG_NUM_DIMS:      cfg_q.num_dims <= nd_wr;
				cvsr_pkg::CFG_SIZE_0:        cfg_q.size[0] <= size_wr;
				cvsr_pkg::CFG_SIZE_1:        cfg_q.size[1] <= size_wr;
				cvsr_pkg::CFG_SIZE_2:        cfg_q.size[2] <= size_wr;
				cvsr_pkg::CFG_SIZE_3:        cfg_q.size[3] <= size_wr;
				cvsr_pkg::CFG_PERIODIC_MASK: cfg_q.periodic <=
					wdata[cvsr_pkg::PMASK_BITS-1:0];
				cvsr_pkg::CFG_OWN_COORDS:    cfg_q.own_coords <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/cvsr_wrap.sv
// ----------------------------------------------------------------------------
// Coordinate offset and wrap pipeline
// Forms own+shift and own-shift per dimension, checks the grid bounds and
// reduces periodic coordinates modulo the size with a pipelined remainder
// unit that resolves eight bits of the magnitude per stage.
// ----------------------------------------------------------------------------
module cvsr_wrap #(
	parameter int MAX_DIMS   = 4,
	parameter int COORD_BITS = 8,
	parameter int SHIFT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cvsr_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	input  logic [SHIFT_BITS-1:0]           shift [MAX_DIMS],
	output logic                            out_valid,
	output logic                            out_ok [cvsr_pkg::NUM_DIRS],
	output logic [cvsr_pkg::SIZE_BITS-1:0]  out_coord [cvsr_pkg::NUM_DIRS][MAX_DIMS]
);

	localparam int SB         = cvsr_pkg::SIZE_BITS;
	localparam int ND         = cvsr_pkg::NUM_DIRS;
	localparam int SUM_BITS   = ((SHIFT_BITS > COORD_BITS) ? SHIFT_BITS : COORD_BITS + 1) + 1;
	localparam int MOD_STAGES = (SUM_BITS + cvsr_pkg::STEP_BITS - 1) / cvsr_pkg::STEP_BITS;
	localparam int PAD_BITS   = MOD_STAGES * cvsr_pkg::STEP_BITS;
	localparam int OWN_BITS   = (MAX_DIMS * COORD_BITS > cvsr_pkg::CFG_BITS) ?
		MAX_DIMS * COORD_BITS : cvsr_pkg::CFG_BITS;

	// One restoring remainder step: bring in one bit, subtract the size if it fits.
	function automatic logic [SB-1:0] rem_step(input logic [SB-1:0] r, input logic b,
			input logic [SB-1:0] n);
		logic [SB:0] t;
		t = {r, b};
		if (t >= {1'b0, n}) begin
			rem_step = SB'(t - {1'b0, n});
		end else begin
			rem_step = t[SB-1:0];
		end
	endfunction

	logic [OWN_BITS-1:0]  own_all;
	logic [PAD_BITS-1:0]  mag_d [ND][MAX_DIMS];
	logic                 neg_d [ND][MAX_DIMS];
	logic                 ok_d  [ND];
	logic [SB-1:0]        rem_d [0:MOD_STAGES-1][ND][MAX_DIMS];

	logic [PAD_BITS-1:0]  mag_s   [0:MOD_STAGES-1][ND][MAX_DIMS];
	logic                 neg_s   [0:MOD_STAGES-1][ND][MAX_DIMS];
	logic [SB-1:0]        rem_s   [0:MOD_STAGES][ND][MAX_DIMS];
	logic                 ok_s    [0:MOD_STAGES][ND];
	logic                 valid_s [0:MOD_STAGES];

	assign own_all = OWN_BITS'(cfg.own_coords);

	// First stage: signed offset, magnitude and bounds check per dimension.
	always_comb begin
		logic [SUM_BITS-1:0] own_x;
		logic [SUM_BITS-1:0] sh_x;
		logic [SUM_BITS-1:0] p;
		logic [SUM_BITS-1:0] q;
		logic                in_range;
		for (int d = 0; d < ND; d++) begin
			ok_d[d] = 1'b1;
			for (int k = 0; k < MAX_DIMS; k++) begin
				own_x = SUM_BITS'(own_all[k*COORD_BITS +: COORD_BITS]);
				sh_x  = {{(SUM_BITS-SHIFT_BITS){shift[k][SHIFT_BITS-1]}}, shift[k]};
				if (d == cvsr_pkg::DIR_DEST) begin
					p = own_x + sh_x;
					q = '0 - own_x - sh_x;
				end else begin
					p = own_x - sh_x;
					q = sh_x - own_x;
				end
				neg_d[d][k] = p[SUM_BITS-1];
				mag_d[d][k] = p[SUM_BITS-1] ? PAD_BITS'(q) : PAD_BITS'(p);
				in_range = !p[SUM_BITS-1] && (mag_d[d][k] < PAD_BITS'(cfg.size[k]));
				if ((cvsr_pkg::NDIM_BITS'(k) < cfg.num_dims) && !cfg.periodic[k]
						&& !in_range) begin
					ok_d[d] = 1'b0;
				end
			end
		end
	end

	// Remainder stages: eight magnitude bits per stage, most significant first.
	always_comb begin
		logic [SB-1:0] r;
		for (int j = 0; j < MOD_STAGES; j++) begin
			for (int d = 0; d < ND; d++) begin
				for (int k = 0; k < MAX_DIMS; k++) begin
					r = rem_s[j][d][k];
					for (int i = 0; i < cvsr_pkg::STEP_BITS; i++) begin
						r = rem_step(r,
							mag_s[j][d][k][PAD_BITS-1-cvsr_pkg::STEP_BITS*j-i],
							cfg.size[k]);
					end
					// Last stage: fold in the sign, or pass the plain coordinate.
					if (j == MOD_STAGES - 1) begin
						if (!cfg.periodic[k]) begin
							r = mag_s[j][d][k][SB-1:0];
						end else if (neg_s[j][d][k] && (r != '0)) begin
							r = cfg.size[k] - r;
						end
					end
					rem_d[j][d][k] = r;
				end
			end
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= MOD_STAGES; j++) begin
				valid_s[j] <= 1'b0;
			end
		end else begin
			valid_s[0] <= in_valid;
			for (int j = 0; j < MOD_STAGES; j++) begin
				valid_s[j+1] <= valid_s[j];
			end
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		for (int d = 0; d < ND; d++) begin
			ok_s[0][d] <= ok_d[d];
			for (int k = 0; k < MAX_DIMS; k++) begin
				mag_s[0][d][k] <= mag_d[d][k];
				neg_s[0][d][k] <= neg_d[d][k];
				rem_s[0][d][k] <= '0;
			end
			for (int j = 0; j < MOD_STAGES; j++) begin
				ok_s[j+1][d] <= ok_s[j][d];
				for (int k = 0; k < MAX_DIMS; k++) begin
					rem_s[j+1][d][k] <= rem_d[j][d][k];
					if (j < MOD_STAGES - 1) begin
						mag_s[j+1][d][k] <= mag_s[j][d][k];
						neg_s[j+1][d][k] <= neg_s[j][d][k];
					end
				end
			end
		end
	end

	assign out_valid = valid_s[MOD_STAGES];
	assign out_ok    = ok_s[MOD_STAGES];
	assign out_coord = rem_s[MOD_STAGES];

endmodule

>>> rtl/cvsr_rank.sv
// ----------------------------------------------------------------------------
// Row-major rank pipeline
// Horner evaluation of the rank, one dimension per stage:
// acc = acc * size + coord. Dimensions beyond the count in use leave the
// accumulator unchanged.
// ----------------------------------------------------------------------------
module cvsr_rank #(
	parameter int MAX_DIMS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cvsr_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	input  logic                            in_ok [cvsr_pkg::NUM_DIRS],
	input  logic [cvsr_pkg::SIZE_BITS-1:0]  in_coord [cvsr_pkg::NUM_DIRS][MAX_DIMS],
	output logic                            out_valid,
	output logic                            out_ok [cvsr_pkg::NUM_DIRS],
	output logic [cvsr_pkg::RANK_BITS-1:0]  out_rank [cvsr_pkg::NUM_DIRS]
);

	localparam int SB = cvsr_pkg::SIZE_BITS;
	localparam int RB = cvsr_pkg::RANK_BITS;
	localparam int ND = cvsr_pkg::NUM_DIRS;

	logic [RB-1:0] acc_s   [0:MAX_DIMS-1][ND];
	logic [SB-1:0] coord_s [0:MAX_DIMS-1][ND][MAX_DIMS];
	logic          ok_s    [0:MAX_DIMS-1][ND];
	logic          valid_s [0:MAX_DIMS-1];

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_DIMS; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else begin
			valid_s[0] <= in_valid;
			for (int k = 1; k < MAX_DIMS; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	// Accumulator stages. Dimension zero is always in use.
	always_ff @(posedge clk) begin
		for (int d = 0; d < ND; d++) begin
			acc_s[0][d]   <= RB'(in_coord[d][0]);
			coord_s[0][d] <= in_coord[d];
			ok_s[0][d]    <= in_ok[d];
			for (int k = 1; k < MAX_DIMS; k++) begin
				coord_s[k][d] <= coord_s[k-1][d];
				ok_s[k][d]    <= ok_s[k-1][d];
				if (cvsr_pkg::NDIM_BITS'(k) < cfg.num_dims) begin
					acc_s[k][d] <= acc_s[k-1][d] * RB'(cfg.size[k])
						+ RB'(coord_s[k-1][d][k]);
				end else begin
					acc_s[k][d] <= acc_s[k-1][d];
				end
			end
		end
	end

	assign out_valid = valid_s[MAX_DIMS-1];
	assign out_ok    = ok_s[MAX_DIMS-1];
	assign out_rank  = acc_s[MAX_DIMS-1];

endmodule

>>> rtl/cartesian_vector_shift_ranks.sv
// ----------------------------------------------------------------------------
// Cartesian vector shift ranks
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the remainder unit (eight bits per stage) and one
// multiply-add stage per dimension. Reset clears all valid bits and loads the
// register defaults. Results are shown for one cycle, marked by done.
// ----------------------------------------------------------------------------
module cartesian_vector_shift_ranks #(
	parameter int MAX_DIMS   = 4,
	parameter int COORD_BITS = 8,
	parameter int SHIFT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cvsr_pkg::NDIM_BITS-1:0]       cfg_index,
	input  logic [cvsr_pkg::CFG_BITS-1:0]        cfg_wdata,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [SHIFT_BITS-1:0]         shift_0,
	input  logic signed [SHIFT_BITS-1:0]         shift_1,
	input  logic signed [SHIFT_BITS-1:0]         shift_2,
	input  logic signed [SHIFT_BITS-1:0]         shift_3,
	output logic                                 done,
	output logic                                 dest_valid,
	output logic [cvsr_pkg::RANK_BITS-1:0]       dest_rank,
	output logic                                 source_valid,
	output logic [cvsr_pkg::RANK_BITS-1:0]       source_rank
);

	localparam int SB = cvsr_pkg::SIZE_BITS;
	localparam int RB = cvsr_pkg::RANK_BITS;
	localparam int ND = cvsr_pkg::NUM_DIRS;

	cvsr_pkg::cfg_t         cfg;
	logic [SHIFT_BITS-1:0]  shift_all [cvsr_pkg::FIELD_DIMS];
	logic [SHIFT_BITS-1:0]  shift_arr [MAX_DIMS];
	logic                   wrap_valid;
	logic                   wrap_ok    [ND];
	logic [SB-1:0]          wrap_coord [ND][MAX_DIMS];
	logic                   rank_valid;
	logic                   rank_ok    [ND];
	logic [RB-1:0]          rank_acc   [ND];

	logic                   done_q;
	logic                   dest_valid_q;
	logic [RB-1:0]          dest_rank_q;
	logic                   source_valid_q;
	logic [RB-1:0]          source_rank_q;

	// The pipeline takes a request every cycle.
	assign busy = 1'b0;

	// Gather the shift fields of the dimensions this build supports.
	assign shift_all[0] = shift_0;
	assign shift_all[1] = shift_1;
	assign shift_all[2] = shift_2;
	assign shift_all[3] = shift_3;

	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_shift
		assign shift_arr[k] = shift_all[k];
	end

	// Configuration registers.
	cvsr_cfg #(
		.MAX_DIMS (MAX_DIMS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// Offset, bounds check and periodic wrap.
	cvsr_wrap #(
		.MAX_DIMS   (MAX_DIMS),
		.COORD_BITS (COORD_BITS),
		.SHIFT_BITS (SHIFT_BITS)
	) u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (start & !busy),
		.shift     (shift_arr),
		.out_valid (wrap_valid),
		.out_ok    (wrap_ok),
		.out_coord (wrap_coord)
	);

	// Row-major linearization.
	cvsr_rank #(
		.MAX_DIMS (MAX_DIMS)
	) u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (wrap_valid),
		.in_ok     (wrap_ok),
		.in_coord  (wrap_coord),
		.out_valid (rank_valid),
		.out_ok    (rank_ok),
		.out_rank  (rank_acc)
	);

	// Output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rank_valid;
		end
	end

	// Output payload: a null result carries rank zero.
	always_ff @(posedge clk) begin
		dest_valid_q   <= rank_ok[cvsr_pkg::DIR_DEST];
		dest_rank_q    <= rank_ok[cvsr_pkg::DIR_DEST] ? rank_acc[cvsr_pkg::DIR_DEST] : '0;
		source_valid_q <= rank_ok[cvsr_pkg::DIR_SRC];
		source_rank_q  <= rank_ok[cvsr_pkg::DIR_SRC] ? rank_acc[cvsr_pkg::DIR_SRC] : '0;
	end

	assign done         = done_q;
	assign dest_valid   = dest_valid_q;
	assign dest_rank    = dest_rank_q;
	assign source_valid = source_valid_q;
	assign source_rank  = source_rank_q;

endmodule
